/* sv/gvc_pkg.sv */
// ----------------------------------------------------------------------------
// gvc_pkg
// Shared constants and the sequencer state type of the greedy vertex cover
// block.
// ----------------------------------------------------------------------------
package gvc_pkg;

	localparam int MAX_VERTICES_DEF = 32;
	localparam int VTX_W            = 5;
	localparam int CNT_W            = 6;
	localparam int SCORE_W          = 10;
	localparam logic [CNT_W-1:0] CNT_RESET = 6'd32;

	localparam logic CMD_ADD = 1'b0;
	localparam logic CMD_RUN = 1'b1;

	typedef enum logic [3:0] {
		S_IDLE,
		S_ADD_A,
		S_ADD_B,
		S_ROW,
		S_ACC,
		S_FIN,
		S_DRD,
		S_DCAP,
		S_DSCAN,
		S_DWR,
		S_DEND,
		S_EMIT
	} gvc_state_t;

endpackage

/* sv/greedy_vertex_cover_top.sv */
// ----------------------------------------------------------------------------
// greedy_vertex_cover_top
// Greedy vertex cover over an adjacency bit matrix held in a synchronous
// memory, with vertex degrees in a second memory.
//
//  channel | direction | handshake          | contents
//  s       | in        | s_tvalid/s_tready  | cmd (tuser), vertex_a, vertex_b
//  m       | out       | m_tvalid/m_tready  | chosen, empty (tuser), last, sizes
//  cfg     | in        | cfg_we             | vertex_count
//
// An edge add reads row a, then writes row a and row b; a duplicate edge
// stops after the read. A run, per pick, scores every vertex (one degree
// memory read per neighbor slot), drops the pick from its neighbors' rows
// and its own, then emits; the degree read port sets the length of a run.
// Reset and a vertex_count write clear the graph at once through per-row
// valid bits. A stalled output holds the sequencer in its emit state.
// ----------------------------------------------------------------------------
module greedy_vertex_cover_top
	import gvc_pkg::*;
#(
	parameter int MAX_VERTICES = MAX_VERTICES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [4:0] vertex_a, [9:5] vertex_b, rest zero
	input  logic [0:0]  s_tuser,   // [0] cmd
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // [4:0] chosen_vertex, [10:5] cover_size,
	                               // [16:11] remaining_count, rest zero
	output logic [0:0]  m_tuser,   // [0] cover_empty
	output logic        m_tlast,
	input  logic        cfg_we,
	input  logic [5:0]  cfg_data
);

	localparam int VW  = $clog2(MAX_VERTICES);
	localparam int DW  = $clog2(MAX_VERTICES);
	localparam int ETW = $clog2(MAX_VERTICES * (MAX_VERTICES - 1) / 2 + 1);
	localparam logic [7:0] MAX8 = 8'(MAX_VERTICES);

	gvc_state_t state_q, state_d;

	// memories
	logic [MAX_VERTICES-1:0] adj_mem [MAX_VERTICES];
	logic [DW-1:0]           deg_mem [MAX_VERTICES];
	logic [MAX_VERTICES-1:0] adj_rd_q, adj_rdata;
	logic [DW-1:0]           deg_rd_q, deg_rdata;
	logic [VW-1:0]           adj_ra_s1, deg_ra_s1;
	logic [MAX_VERTICES-1:0] vld_q;

	logic                    mem_we;
	logic [VW-1:0]           mem_wa, adj_ra, deg_ra;
	logic [MAX_VERTICES-1:0] adj_wd;
	logic [DW-1:0]           deg_wd;

	// state
	logic [CNT_W-1:0]        cnt_q;
	logic [ETW-1:0]          edge_q;
	logic [CNT_W-1:0]        picked_q;
	logic [VW-1:0]           a_q, b_q, k_q, j_q, j_s1, best_q;
	logic [MAX_VERTICES-1:0] row_q;
	logic [DW-1:0]           degk_q, bestdeg_q;
	logic [SCORE_W-1:0]      sum_q, top_q;
	logic                    acc_v_s1, empty_q;

	// output register
	logic                    out_v_q;
	logic [VTX_W-1:0]        o_vtx_q;
	logic                    o_empty_q, o_last_q;
	logic [CNT_W-1:0]        o_size_q, o_rem_q;

	// derived values
	logic [7:0]              n8, a8, b8;
	logic [VW-1:0]           last_idx, a_idx, b_idx;
	logic                    accept, edge_ok, out_free, run_last;
	logic [SCORE_W-1:0]      contrib, score;
	logic                    take;
	logic [MAX_VERTICES-1:0] best_bit, a_bit, b_bit;

	// effective vertex count
	always_comb begin
		if (cnt_q == '0)
			n8 = 8'd1;
		else if ({2'b00, cnt_q} > MAX8)
			n8 = MAX8;
		else
			n8 = {2'b00, cnt_q};
	end

	assign last_idx = VW'(n8 - 8'd1);
	assign a8       = {3'b000, s_tdata[4:0]};
	assign b8       = {3'b000, s_tdata[9:5]};
	assign a_idx    = a8[VW-1:0];
	assign b_idx    = b8[VW-1:0];
	assign edge_ok  = (a8 != b8) && (a8 < n8) && (b8 < n8);
	assign accept   = s_tvalid && s_tready;
	assign s_tready = (state_q == S_IDLE);
	assign out_free = !out_v_q || m_tready;
	assign run_last = (edge_q == '0);
	assign best_bit = MAX_VERTICES'(1) << best_q;
	assign a_bit    = MAX_VERTICES'(1) << a_q;
	assign b_bit    = MAX_VERTICES'(1) << b_q;

	// unwritten rows read as empty
	assign adj_rdata = vld_q[adj_ra_s1] ? adj_rd_q : '0;
	assign deg_rdata = vld_q[deg_ra_s1] ? deg_rd_q : '0;

	// scoring: neighbor degree returned in the cycle after its read
	assign contrib = (acc_v_s1 && row_q[j_s1]) ? SCORE_W'(deg_rdata) : '0;
	assign score   = sum_q + contrib;
	assign take    = (k_q == '0) || (score > top_q) ||
	                 ((score == top_q) && (degk_q > bestdeg_q));

	// next state and memory control
	always_comb begin
		state_d = state_q;
		mem_we  = 1'b0;
		mem_wa  = '0;
		adj_wd  = '0;
		deg_wd  = '0;
		adj_ra  = '0;
		deg_ra  = '0;
		case (state_q)
			S_IDLE: begin
				adj_ra = a_idx;
				deg_ra = a_idx;
				if (accept) begin
					if (s_tuser[0] == CMD_RUN)
						state_d = run_last ? S_EMIT : S_ROW;
					else if (edge_ok)
						state_d = S_ADD_A;
				end
			end
			S_ADD_A: begin
				adj_ra = b_q;
				deg_ra = b_q;
				if (adj_rdata[b_q]) begin
					state_d = S_IDLE;
				end else begin
					mem_we  = 1'b1;
					mem_wa  = a_q;
					adj_wd  = adj_rdata | b_bit;
					deg_wd  = deg_rdata + DW'(1);
					state_d = S_ADD_B;
				end
			end
			S_ADD_B: begin
				mem_we  = 1'b1;
				mem_wa  = b_q;
				adj_wd  = adj_rdata | a_bit;
				deg_wd  = deg_rdata + DW'(1);
				state_d = S_IDLE;
			end
			S_ROW: begin
				adj_ra  = k_q;
				deg_ra  = k_q;
				state_d = S_ACC;
			end
			S_ACC: begin
				deg_ra = j_q;
				if (j_q == last_idx)
					state_d = S_FIN;
			end
			S_FIN: begin
				state_d = (k_q == last_idx) ? S_DRD : S_ROW;
			end
			S_DRD: begin
				adj_ra  = best_q;
				state_d = S_DCAP;
			end
			S_DCAP: begin
				state_d = S_DSCAN;
			end
			S_DSCAN: begin
				adj_ra = j_q;
				deg_ra = j_q;
				if (row_q[j_q])
					state_d = S_DWR;
				else if (j_q == last_idx)
					state_d = S_DEND;
			end
			S_DWR: begin
				mem_we  = 1'b1;
				mem_wa  = j_q;
				adj_wd  = adj_rdata & ~best_bit;
				deg_wd  = (deg_rdata != '0) ? deg_rdata - DW'(1) : deg_rdata;
				state_d = (j_q == last_idx) ? S_DEND : S_DSCAN;
			end
			S_DEND: begin
				mem_we  = 1'b1;
				mem_wa  = best_q;
				state_d = S_EMIT;
			end
			S_EMIT: begin
				if (out_free)
					state_d = (empty_q || run_last) ? S_IDLE : S_ROW;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

	// memories: one write port, registered read ports
	always_ff @(posedge clk) begin
		if (mem_we) begin
			adj_mem[mem_wa] <= adj_wd;
			deg_mem[mem_wa] <= deg_wd;
		end
		adj_rd_q  <= adj_mem[adj_ra];
		deg_rd_q  <= deg_mem[deg_ra];
		adj_ra_s1 <= adj_ra;
		deg_ra_s1 <= deg_ra;
	end

	// row valid bits, count register, edge total and pick count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			cnt_q    <= CNT_RESET;
			edge_q   <= '0;
			picked_q <= '0;
			empty_q  <= 1'b0;
			acc_v_s1 <= 1'b0;
		end else begin
			acc_v_s1 <= (state_q == S_ACC);
			if (cfg_we) begin
				cnt_q  <= cfg_data;
				vld_q  <= '0;
				edge_q <= '0;
			end else begin
				if (mem_we)
					vld_q[mem_wa] <= 1'b1;
				if (state_q == S_ADD_B)
					edge_q <= edge_q + ETW'(1);
				else if (state_q == S_DWR && edge_q != '0)
					edge_q <= edge_q - ETW'(1);
			end
			if (accept && s_tuser[0] == CMD_RUN) begin
				picked_q <= '0;
				empty_q  <= run_last;
			end else if (state_q == S_DEND) begin
				picked_q <= picked_q + CNT_W'(1);
			end
		end
	end

	// working registers of the sequencer
	always_ff @(posedge clk) begin
		j_s1 <= j_q;
		case (state_q)
			S_IDLE: begin
				a_q <= a_idx;
				b_q <= b_idx;
				k_q <= '0;
			end
			S_ROW: begin
				sum_q <= '0;
				j_q   <= '0;
			end
			S_ACC: begin
				if (j_q == '0) begin
					row_q  <= adj_rdata;
					degk_q <= deg_rdata;
				end
				sum_q <= score;
				j_q   <= j_q + VW'(1);
			end
			S_FIN: begin
				if (take) begin
					best_q    <= k_q;
					top_q     <= score;
					bestdeg_q <= degk_q;
				end
				k_q <= k_q + VW'(1);
			end
			S_DCAP: begin
				row_q <= adj_rdata;
				j_q   <= '0;
			end
			S_DSCAN: begin
				if (!row_q[j_q])
					j_q <= j_q + VW'(1);
			end
			S_DWR: begin
				j_q <= j_q + VW'(1);
			end
			S_EMIT: begin
				k_q <= '0;
			end
			default: begin
			end
		endcase
	end

	// output register: load on emit, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_v_q <= 1'b0;
		else if (state_q == S_EMIT && out_free)
			out_v_q <= 1'b1;
		else if (m_tready)
			out_v_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (state_q == S_EMIT && out_free) begin
			if (empty_q) begin
				o_vtx_q   <= '0;
				o_empty_q <= 1'b1;
				o_last_q  <= 1'b1;
				o_size_q  <= '0;
				o_rem_q   <= CNT_W'(n8);
			end else begin
				o_vtx_q   <= VTX_W'({2'b00, best_q});
				o_empty_q <= 1'b0;
				o_last_q  <= run_last;
				o_size_q  <= picked_q;
				o_rem_q   <= run_last ? CNT_W'(n8 - {2'b00, picked_q}) : '0;
			end
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = {7'd0, o_rem_q, o_size_q, o_vtx_q};
	assign m_tuser  = o_empty_q;
	assign m_tlast  = o_last_q;

endmodule
